@@ src/assert_macros.svh @@
// Assertion macros shared by the chain manager RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define FCM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCM_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define FCM_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ src/fcm_pkg.sv @@
// Constants and operation codes of the cluster chain manager.
// No dependencies.
`timescale 1ns / 1ps
package fcm_pkg;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int FIELD_W = 16;
    localparam int CNT_W = 11;
    localparam int WORD_BITS = 32;
    localparam int WORD_SHIFT = 5;

    localparam logic [FIELD_W-1:0] CHAIN_END = 16'hFFFF;
    localparam logic [FIELD_W-1:0] FREE_ENTRY = 16'h0000;
    localparam logic [CNT_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [1:0] OP_NEXT = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;
endpackage

@@ src/fcm_ram.sv @@
// Single-port synchronous RAM with a registered read, read-first.
// No dependencies.
`timescale 1ns / 1ps
module fcm_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[addr];
        if (we) begin
            mem_reg[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ src/fat_cluster_chain_manager.sv @@
// Top level of the cluster chain manager: sequencer, free bitmap row flags, output register.
// Depends on fcm_pkg, fcm_ram and assert_macros.svh.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_operation s_cluster s_entry_value
//  m_      | out       | m_valid m_ready m_result_cluster m_found
//  cfg_    | in        | cfg_valid cfg_ready cfg_clusters_in_use
//
// Next reads, then checks the entry; allocate reads a bitmap row, then claims a bit;
// append also loads after a valid cluster; load writes the entry, then its bitmap row;
// rejects at decode go to the response. One RAM step per cycle. After reset a clearing
// pass writes all table and bitmap entries with s_ready low. A result waits in the output
// register; the next item is accepted meanwhile and only its final step waits for it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fat_cluster_chain_manager #(
    parameter int TABLE_DEPTH = fcm_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [fcm_pkg::FIELD_W-1:0] s_cluster,
    input  logic [fcm_pkg::FIELD_W-1:0] s_entry_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fcm_pkg::FIELD_W-1:0] m_result_cluster,
    output logic                        m_found,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fcm_pkg::CNT_W-1:0]   cfg_clusters_in_use
);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int ROWS = (TABLE_DEPTH + fcm_pkg::WORD_BITS - 1) / fcm_pkg::WORD_BITS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WB = fcm_pkg::WORD_BITS;
    localparam int FW = fcm_pkg::FIELD_W;
    localparam int BW = fcm_pkg::WORD_SHIFT;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DEC = 4'd2;
    localparam logic [3:0] ST_NRD = 4'd3;
    localparam logic [3:0] ST_NCHK = 4'd4;
    localparam logic [3:0] ST_ARD = 4'd5;
    localparam logic [3:0] ST_ACHK = 4'd6;
    localparam logic [3:0] ST_LRD = 4'd7;
    localparam logic [3:0] ST_LWR = 4'd8;
    localparam logic [3:0] ST_RESP = 4'd9;

    logic [3:0]                 state_reg, state_next;
    logic [ADDR_W-1:0]          clr_reg, clr_next;
    logic [fcm_pkg::CNT_W-1:0]  cfg_reg;
    logic [ROWS-1:0]            row_free_reg, row_free_next;
    logic                       m_valid_reg, m_valid_next;
    logic [1:0]                 op_reg, op_next;
    logic [FW-1:0]              clu_reg, clu_next;
    logic [FW-1:0]              val_reg, val_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic                       any_reg, any_next;
    logic [FW-1:0]              res_reg, res_next;
    logic                       found_reg, found_next;
    logic [FW-1:0]              m_res_reg, m_res_next;
    logic                       m_found_reg, m_found_next;

    logic                       tbl_we;
    logic [ADDR_W-1:0]          tbl_addr;
    logic [FW-1:0]              tbl_wdata;
    logic [FW-1:0]              tbl_rdata;
    logic                       bm_we;
    logic [ROW_W-1:0]           bm_addr;
    logic [WB-1:0]              bm_wdata;
    logic [WB-1:0]              bm_rdata;

    logic [FW:0]                eff_cnt;
    logic                       clu_valid;
    logic                       clu_in_tbl;
    logic [ROW_W-1:0]           clu_row;
    logic [ROW_W-1:0]           first_row;
    logic                       any_free;
    logic [BW-1:0]              low_bit;
    logic                       word_nz;
    logic [FW-1:0]              alloc_idx;
    logic                       alloc_ok;
    logic [WB-1:0]              alloc_word;
    logic [WB-1:0]              load_word;
    logic [WB-1:0]              clr_mask;
    logic                       out_free;
    logic                       accept;

    fcm_ram #(.DATA_W(FW), .DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    fcm_ram #(.DATA_W(WB), .DEPTH(ROWS), .ADDR_W(ROW_W)) u_bitmap (
        .aclk  (aclk),
        .we    (bm_we),
        .addr  (bm_addr),
        .wdata (bm_wdata),
        .rdata (bm_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_result_cluster = m_res_reg;
    assign m_found = m_found_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign eff_cnt = ({6'b0, cfg_reg} > (FW + 1)'(TABLE_DEPTH)) ?
                     (FW + 1)'(TABLE_DEPTH) : {6'b0, cfg_reg};
    assign clu_valid = {1'b0, clu_reg} < eff_cnt;
    assign clu_in_tbl = {1'b0, clu_reg} < (FW + 1)'(TABLE_DEPTH);
    assign clu_row = ROW_W'(clu_reg >> BW);
    assign alloc_idx = FW'({row_reg, low_bit});
    assign alloc_ok = word_nz && ({1'b0, alloc_idx} < eff_cnt);

    always_comb begin
        first_row = '0;
        any_free = 1'b0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (row_free_reg[i]) begin
                first_row = ROW_W'(i);
                any_free = 1'b1;
            end
        end
    end

    always_comb begin
        low_bit = '0;
        word_nz = 1'b0;
        for (int j = WB - 1; j >= 0; j--) begin
            if (bm_rdata[j]) begin
                low_bit = BW'(j);
                word_nz = 1'b1;
            end
        end
    end

    always_comb begin
        alloc_word = bm_rdata & ~(WB'(1) << low_bit);
        load_word = bm_rdata;
        load_word[clu_reg[BW-1:0]] = (val_reg == fcm_pkg::FREE_ENTRY);
        for (int j = 0; j < WB; j++) begin
            clr_mask[j] = (int'(clr_reg) * WB + j) < TABLE_DEPTH;
        end
    end

    always_comb begin
        tbl_we = 1'b0;
        tbl_addr = clu_reg[ADDR_W-1:0];
        tbl_wdata = val_reg;
        bm_we = 1'b0;
        bm_addr = row_reg;
        bm_wdata = load_word;
        case (state_reg)
            ST_CLEAR: begin
                tbl_we = 1'b1;
                tbl_addr = clr_reg;
                tbl_wdata = fcm_pkg::FREE_ENTRY;
                bm_we = (int'(clr_reg) < ROWS);
                bm_addr = clr_reg[ROW_W-1:0];
                bm_wdata = clr_mask;
            end
            ST_ACHK: begin
                tbl_we = alloc_ok;
                tbl_addr = alloc_idx[ADDR_W-1:0];
                tbl_wdata = fcm_pkg::CHAIN_END;
                bm_we = alloc_ok;
                bm_wdata = alloc_word;
            end
            ST_LRD: begin
                tbl_we = 1'b1;
                bm_addr = clu_row;
            end
            ST_LWR: begin
                bm_we = 1'b1;
                bm_addr = clu_row;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        row_free_next = row_free_reg;
        m_valid_next = m_valid_reg;
        op_next = op_reg;
        clu_next = clu_reg;
        val_next = val_reg;
        row_next = row_reg;
        any_next = any_reg;
        res_next = res_reg;
        found_next = found_reg;
        m_res_next = m_res_reg;
        m_found_next = m_found_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + ADDR_W'(1);
                if (int'(clr_reg) == TABLE_DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    op_next = s_operation;
                    clu_next = s_cluster;
                    val_next = s_entry_value;
                    row_next = first_row;
                    any_next = any_free;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                res_next = fcm_pkg::CHAIN_END;
                found_next = 1'b0;
                state_next = ST_RESP;
                case (op_reg)
                    fcm_pkg::OP_NEXT: begin
                        if (clu_valid) begin
                            state_next = ST_NRD;
                        end
                    end
                    fcm_pkg::OP_ALLOC, fcm_pkg::OP_APPEND: begin
                        if (any_reg) begin
                            state_next = ST_ARD;
                        end
                    end
                    fcm_pkg::OP_LOAD: begin
                        if (clu_in_tbl) begin
                            res_next = clu_reg;
                            found_next = 1'b1;
                            state_next = ST_LRD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_NRD: begin
                state_next = ST_NCHK;
            end
            ST_NCHK: begin
                if ({1'b0, tbl_rdata} < eff_cnt) begin
                    res_next = tbl_rdata;
                    found_next = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_ARD: begin
                state_next = ST_ACHK;
            end
            ST_ACHK: begin
                state_next = ST_RESP;
                if (alloc_ok) begin
                    res_next = alloc_idx;
                    found_next = 1'b1;
                    row_free_next[row_reg] = (alloc_word != '0);
                    if (op_reg == fcm_pkg::OP_APPEND && clu_valid) begin
                        val_next = alloc_idx;
                        state_next = ST_LRD;
                    end
                end
            end
            ST_LRD: begin
                state_next = ST_LWR;
            end
            ST_LWR: begin
                row_free_next[clu_row] = (load_word != '0);
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next = res_reg;
                    m_found_next = found_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            cfg_reg <= fcm_pkg::CFG_RESET;
            row_free_reg <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            row_free_reg <= row_free_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_clusters_in_use;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        clu_reg <= clu_next;
        val_reg <= val_next;
        row_reg <= row_next;
        any_reg <= any_next;
        res_reg <= res_next;
        found_reg <= found_next;
        m_res_reg <= m_res_next;
        m_found_reg <= m_found_next;
    end

    `FCM_ASSERT_IMP(a_found_in_table, aclk, aresetn, m_valid && m_found, {1'b0, m_result_cluster} < (FW + 1)'(TABLE_DEPTH), "found result outside the table")
    `FCM_ASSERT_IMP(a_fail_chain_end, aclk, aresetn, m_valid && !m_found, m_result_cluster == fcm_pkg::CHAIN_END, "failed result is not chain end")
    `FCM_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_ready, "item accepted during the clearing pass")
    `FCM_ASSERT_NXT(a_accept_decode, aclk, aresetn, s_valid && s_ready, state_reg == ST_DEC, "accepted item not decoded")
endmodule
